// ----- src/espe_pkg.sv -----
`default_nettype none

package espe_pkg;

  // APB register map
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_COUNTS_PER_REV   = 1'b0;
  localparam logic REG_SAMPLE_PERIOD_US = 1'b1;

  localparam logic [15:0] COUNTS_PER_REV_RST   = 16'd1000;
  localparam logic [19:0] SAMPLE_PERIOD_US_RST = 20'd10000;

  // Fixed-point scale factors: 60 s * 1e6 us * 16, and 360 deg * 16
  localparam logic [29:0] SPEED_SCALE = 30'd960000000;
  localparam logic [29:0] POS_SCALE   = 30'd5760;

  // Shared divider geometry
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 36;
  localparam int STEP_W     = $clog2(DIVIDEND_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIVIDEND_W - 1);

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_WRAP      = 2'd1,
    OP_RESET_POS = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] count_value;
    logic        count_up;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] speed_rpm_q4;
    logic signed [31:0] extended_count;
    logic signed [31:0] position_deg_q4;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SUM,
    ST_MUL_SPD,
    ST_DIV_SPD,
    ST_MUL_POS,
    ST_DIV_POS,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ----- src/espe_regs.sv -----
`default_nettype none

module espe_regs import espe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic      [15:0]       counts_per_rev,
  output logic      [19:0]       sample_period_us
);

  logic wr_en;
  logic reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Update the selected register on the access phase of a write
  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev   <= COUNTS_PER_REV_RST;
      sample_period_us <= SAMPLE_PERIOD_US_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_COUNTS_PER_REV:   counts_per_rev   <= pwdata[15:0];
        REG_SAMPLE_PERIOD_US: sample_period_us <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_COUNTS_PER_REV:   prdata = {16'd0, counts_per_rev};
      REG_SAMPLE_PERIOD_US: prdata = {12'd0, sample_period_us};
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/espe_div.sv -----
`default_nettype none

module espe_div import espe_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic      [DIVIDEND_W-1:0] quotient,
  output div_status_t                status
);

  logic [DIVIDEND_W-1:0] num;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [STEP_W-1:0]     step;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, num[DIVIDEND_W-1]};
    diff     = trial - {1'b0, dvs};
    fits     = (trial >= {1'b0, dvs});
    rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  // Sequencing flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits into the dividend register as it empties
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      num <= {num[DIVIDEND_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient    = num;
  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

// ----- src/encoder_speed_position_estimator.sv -----
// Timing: a tick runs the speed and then the position division (each skipped when
//   its divisor is zero), then loads the output; wrap/reset requests act on acceptance.
// Ticks do not overlap: two 64-step divisions run on one restoring divider shared
//   by speed and position; in_stall is high while a tick runs.
// Reset: synchronous active-high rst clears the revolution counters, the stored count
//   and the output valid, and loads counts_per_rev = 1000, sample_period_us = 10000.
`default_nettype none

module encoder_speed_position_estimator import espe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  function automatic logic signed [31:0] sat_apply(input logic neg,
                                                   input logic [DIVIDEND_W-1:0] mag);
    logic signed [31:0] res;
    if (!neg) begin
      res = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
    end else begin
      res = (mag > 64'h8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - mag[31:0]);
    end
    return res;
  endfunction

  logic [15:0] counts_per_rev;
  logic [19:0] sample_period_us;

  state_t state;
  state_t state_next;

  logic [15:0]        previous_count;
  logic [15:0]        speed_revolutions;
  logic [15:0]        position_revolutions;
  logic [15:0]        cnt;
  logic signed [32:0] prod_spd;
  logic signed [32:0] prod_pos;
  logic [35:0]        per_cpr;
  logic signed [33:0] delta;
  logic signed [31:0] ext;
  logic signed [31:0] speed;
  logic signed [31:0] pos;

  logic               in_accept;
  logic               out_free;
  logic               div_start;
  logic               load_out;
  logic               spd_ok;
  logic               pos_ok;
  logic [33:0]        delta_abs;
  logic [31:0]        ext_abs;
  logic [31:0]        mul_a;
  logic [29:0]        mul_b;
  logic [61:0]        mul_p;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quot;
  div_status_t           div_stat;

  espe_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .counts_per_rev   (counts_per_rev),
    .sample_period_us (sample_period_us)
  );

  assign pready = 1'b1;

  espe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({2'b00, mul_p}),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .status   (div_stat)
  );

  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid | ~out_stall;
  assign spd_ok    = (per_cpr != 36'd0);
  assign pos_ok    = (counts_per_rev != 16'd0);

  // Magnitudes and the shared scale multiplier
  always_comb begin
    delta_abs   = delta[33] ? (34'd0 - delta) : delta;
    ext_abs     = ext[31] ? (32'd0 - ext) : ext;
    mul_a       = (state == ST_MUL_SPD) ? delta_abs[31:0] : ext_abs;
    mul_b       = (state == ST_MUL_SPD) ? SPEED_SCALE : POS_SCALE;
    mul_p       = 62'(mul_a) * 62'(mul_b);
    div_divisor = (state == ST_MUL_SPD) ? per_cpr : {20'd0, counts_per_rev};
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid && in_data.opcode == OP_TICK) state_next = ST_PROD;
      ST_PROD:    state_next = ST_SUM;
      ST_SUM:     state_next = ST_MUL_SPD;
      ST_MUL_SPD: state_next = spd_ok ? ST_DIV_SPD : ST_MUL_POS;
      ST_DIV_SPD: if (div_stat.done) state_next = ST_MUL_POS;
      ST_MUL_POS: state_next = pos_ok ? ST_DIV_POS : ST_OUT;
      ST_DIV_POS: if (div_stat.done) state_next = ST_OUT;
      ST_OUT:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    div_start = ((state == ST_MUL_SPD) && spd_ok) || ((state == ST_MUL_POS) && pos_ok);
    load_out  = (state == ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Revolution counters and stored count
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_count       <= '0;
      speed_revolutions    <= '0;
      position_revolutions <= '0;
    end else if (in_accept && in_data.opcode == OP_WRAP) begin
      if (in_data.count_up) begin
        speed_revolutions    <= speed_revolutions + 16'd1;
        position_revolutions <= position_revolutions + 16'd1;
      end else begin
        speed_revolutions    <= speed_revolutions - 16'd1;
        position_revolutions <= position_revolutions - 16'd1;
      end
    end else if (in_accept && in_data.opcode == OP_RESET_POS) begin
      position_revolutions <= '0;
    end else if (state == ST_SUM) begin
      previous_count    <= cnt;
      speed_revolutions <= '0;
    end
  end

  // Tick datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cnt <= in_data.count_value;
    end
    if (state == ST_PROD) begin
      prod_spd <= 33'($signed(speed_revolutions)) * 33'($signed({1'b0, counts_per_rev}));
      prod_pos <= 33'($signed(position_revolutions)) * 33'($signed({1'b0, counts_per_rev}));
      per_cpr  <= 36'(sample_period_us) * 36'(counts_per_rev);
    end
    if (state == ST_SUM) begin
      delta <= $signed({18'd0, cnt}) - $signed({18'd0, previous_count})
               + $signed({prod_spd[32], prod_spd});
      ext   <= 32'($signed({1'b0, cnt}) + prod_pos);
    end
    if (state == ST_MUL_SPD && !spd_ok) begin
      speed <= '0;
    end else if (state == ST_DIV_SPD && div_stat.done) begin
      speed <= sat_apply(delta[33], div_quot);
    end
    if (state == ST_MUL_POS && !pos_ok) begin
      pos <= '0;
    end else if (state == ST_DIV_POS && div_stat.done) begin
      pos <= sat_apply(ext[31], div_quot);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.speed_rpm_q4    <= speed;
      out_data.extended_count  <= ext;
      out_data.position_deg_q4 <= pos;
    end
  end

endmodule

`default_nettype wire
